// ===== sv/nhs_pkg.sv =====
package nhs_pkg;

   // Gradient fraction bits (Q3.28 input format)
   localparam int GRAD_FRAC_BITS = 28;
   localparam int ONE = 1 << GRAD_FRAC_BITS;

   // Field and datapath widths
   localparam int GW = 32;        // gradient entry
   localparam int MODW = 40;      // modulus registers
   localparam int JW = 40;        // determinant J, signed
   localparam int BW = 40;        // strain-like term Bm, signed
   localparam int DW = 36;        // J as a positive divisor
   localparam int KW = 6;         // leading-one position of J
   localparam int EW = 7;         // log2 exponent, signed
   localparam int FW = 32;        // log2 mantissa and fraction
   localparam int LNW = 40;       // ln J with 32 fraction bits, signed
   localparam int CW = 33;        // cofactor entries, signed
   localparam int SW = 64;        // stress results
   localparam int NW = 98;        // numerator before the divide, signed
   localparam int SQ_STEPS = 32;  // squaring steps for the log2 fraction
   localparam int LN2_SHIFT = 24;
   localparam logic signed [24:0] LN2_Q24 = 25'sd11629080;

   // Configuration register map
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_BULK = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHEAR = 8'd1;
   localparam logic [MODW-1:0] BULK_RESET = 40'd7300000;
   localparam logic [MODW-1:0] SHEAR_RESET = 40'd2799248;

   // Saturation bounds
   localparam logic [NW-1:0] SAT_LIMIT = NW'(1) << (SW - 1);
   localparam logic signed [SW-1:0] STRESS_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] STRESS_MIN = {1'b1, {(SW-1){1'b0}}};

   typedef logic signed [NW-1:0] num_type;
   typedef logic signed [SW-1:0] stress_type;

   // Per-item data carried alongside the arithmetic
   typedef struct packed {
      logic                  inv;
      logic signed [GW-1:0]  h00;
      logic signed [GW-1:0]  h01;
      logic signed [GW-1:0]  h10;
      logic signed [GW-1:0]  h11;
      logic signed [BW-1:0]  bm00;
      logic signed [BW-1:0]  bm01;
      logic signed [BW-1:0]  bm11;
      logic signed [JW-1:0]  jac;
   } side_type;

endpackage

// ===== sv/nhs_front.sv =====
module nhs_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [nhs_pkg::GW-1:0]  grad_xx,
   input  logic signed [nhs_pkg::GW-1:0]  grad_xy,
   input  logic signed [nhs_pkg::GW-1:0]  grad_yx,
   input  logic signed [nhs_pkg::GW-1:0]  grad_yy,
   output logic                           out_valid,
   output nhs_pkg::side_type              out_side
);

   logic [2:0]                    v_ff;
   logic signed [nhs_pkg::GW-1:0] h1_ff [4];
   logic signed [nhs_pkg::GW-1:0] h2_ff [4];
   logic signed [63:0]            p_in [8];
   logic signed [63:0]            p_ff [8];
   logic signed [63:0]            det;
   nhs_pkg::side_type             side_in;
   nhs_pkg::side_type             side_ff;

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   // Products for det H and the Bm terms
   always_comb begin
      p_in[0] = h1_ff[0] * h1_ff[3];
      p_in[1] = h1_ff[1] * h1_ff[2];
      p_in[2] = h1_ff[0] * h1_ff[0];
      p_in[3] = h1_ff[1] * h1_ff[1];
      p_in[4] = h1_ff[0] * h1_ff[2];
      p_in[5] = h1_ff[1] * h1_ff[3];
      p_in[6] = h1_ff[2] * h1_ff[2];
      p_in[7] = h1_ff[3] * h1_ff[3];
   end

   // Form J and the symmetric Bm entries
   always_comb begin
      det = p_ff[0] - p_ff[1];
      side_in.inv = 1'b0;
      side_in.h00 = h2_ff[0];
      side_in.h01 = h2_ff[1];
      side_in.h10 = h2_ff[2];
      side_in.h11 = h2_ff[3];
      side_in.jac = nhs_pkg::JW'(nhs_pkg::ONE) + nhs_pkg::JW'(h2_ff[0])
                  + nhs_pkg::JW'(h2_ff[3])
                  + nhs_pkg::JW'(det >>> nhs_pkg::GRAD_FRAC_BITS);
      side_in.bm00 = nhs_pkg::BW'(p_ff[2] >>> nhs_pkg::GRAD_FRAC_BITS)
                   + nhs_pkg::BW'(p_ff[3] >>> nhs_pkg::GRAD_FRAC_BITS)
                   + nhs_pkg::BW'(h2_ff[0]) + nhs_pkg::BW'(h2_ff[0]);
      side_in.bm01 = nhs_pkg::BW'(p_ff[4] >>> nhs_pkg::GRAD_FRAC_BITS)
                   + nhs_pkg::BW'(p_ff[5] >>> nhs_pkg::GRAD_FRAC_BITS)
                   + nhs_pkg::BW'(h2_ff[1]) + nhs_pkg::BW'(h2_ff[2]);
      side_in.bm11 = nhs_pkg::BW'(p_ff[6] >>> nhs_pkg::GRAD_FRAC_BITS)
                   + nhs_pkg::BW'(p_ff[7] >>> nhs_pkg::GRAD_FRAC_BITS)
                   + nhs_pkg::BW'(h2_ff[3]) + nhs_pkg::BW'(h2_ff[3]);
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         h1_ff[0] <= grad_xx;
         h1_ff[1] <= grad_xy;
         h1_ff[2] <= grad_yx;
         h1_ff[3] <= grad_yy;
         h2_ff <= h1_ff;
         p_ff <= p_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_side = side_ff;

endmodule

// ===== sv/nhs_log.sv =====
module nhs_log (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  nhs_pkg::side_type               in_side,
   output logic                            out_valid,
   output nhs_pkg::side_type               out_side,
   output logic signed [nhs_pkg::LNW-1:0]  out_ln
);

   localparam int LAST = nhs_pkg::SQ_STEPS;

   logic [nhs_pkg::DW-1:0]         x_in;
   logic [nhs_pkg::KW-1:0]         k_in;
   nhs_pkg::side_type              sa_in;

   logic                           va_ff;
   nhs_pkg::side_type              sa_ff;
   logic [nhs_pkg::KW-1:0]         k_ff;
   logic [nhs_pkg::DW-1:0]         xa;
   logic [nhs_pkg::FW-1:0]         m0_in;
   logic signed [nhs_pkg::EW-1:0]  e0_in;

   logic                           vq_ff [0:LAST];
   nhs_pkg::side_type              sq_ff [0:LAST];
   logic [nhs_pkg::FW-1:0]         m_ff [0:LAST];
   logic [nhs_pkg::FW-1:0]         m_in [1:LAST];
   logic [nhs_pkg::FW-1:0]         frac_ff [0:LAST];
   logic [nhs_pkg::FW-1:0]         frac_in [1:LAST];
   logic signed [nhs_pkg::EW-1:0]  e_ff [0:LAST];
   logic [63:0]                    sq [0:LAST-1];

   logic signed [nhs_pkg::EW+nhs_pkg::FW-1:0] l2;
   logic signed [63:0]             prod_in;
   logic signed [63:0]             prod_ff;
   logic                           vp_ff;
   nhs_pkg::side_type              sp_ff;
   logic                           vr_ff;
   nhs_pkg::side_type              sr_ff;
   logic signed [nhs_pkg::LNW-1:0] ln_ff;

   // Flag a non-positive J and find its leading one
   always_comb begin
      x_in = in_side.jac[nhs_pkg::DW-1:0];
      k_in = '0;
      for (int i = 0; i < nhs_pkg::DW; i++) begin
         if (x_in[i]) begin
            k_in = nhs_pkg::KW'(i);
         end
      end
      sa_in = in_side;
      sa_in.inv = in_side.jac[nhs_pkg::JW-1] || (in_side.jac == '0);
   end

   // Normalise J to a mantissa in [1,2) with 31 fraction bits
   always_comb begin
      xa = sa_ff.jac[nhs_pkg::DW-1:0];
      if (k_ff >= nhs_pkg::KW'(31)) begin
         m0_in = nhs_pkg::FW'(xa >> (k_ff - nhs_pkg::KW'(31)));
      end else begin
         m0_in = nhs_pkg::FW'(xa << (nhs_pkg::KW'(31) - k_ff));
      end
      e0_in = signed'({1'b0, k_ff}) - nhs_pkg::EW'(nhs_pkg::GRAD_FRAC_BITS);
   end

   // One squaring per stage yields one fraction bit of log2
   always_comb begin
      for (int s = 0; s < LAST; s++) begin
         sq[s] = m_ff[s] * m_ff[s];
         m_in[s+1] = sq[s][63] ? sq[s][63:32] : sq[s][62:31];
         frac_in[s+1] = {frac_ff[s][nhs_pkg::FW-2:0], sq[s][63]};
      end
   end

   // Scale log2 to ln
   always_comb begin
      l2 = signed'({e_ff[LAST], frac_ff[LAST]});
      prod_in = l2 * nhs_pkg::LN2_Q24;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vp_ff <= 1'b0;
         vr_ff <= 1'b0;
         for (int s = 0; s <= LAST; s++) begin
            vq_ff[s] <= 1'b0;
         end
      end else if (en) begin
         va_ff <= in_valid;
         vq_ff[0] <= va_ff;
         for (int s = 1; s <= LAST; s++) begin
            vq_ff[s] <= vq_ff[s-1];
         end
         vp_ff <= vq_ff[LAST];
         vr_ff <= vp_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff <= sa_in;
         k_ff <= k_in;
         sq_ff[0] <= sa_ff;
         m_ff[0] <= m0_in;
         frac_ff[0] <= '0;
         e_ff[0] <= e0_in;
         for (int s = 1; s <= LAST; s++) begin
            sq_ff[s] <= sq_ff[s-1];
            m_ff[s] <= m_in[s];
            frac_ff[s] <= frac_in[s];
            e_ff[s] <= e_ff[s-1];
         end
         sp_ff <= sq_ff[LAST];
         prod_ff <= prod_in;
         sr_ff <= sp_ff;
         ln_ff <= nhs_pkg::LNW'(prod_ff >>> nhs_pkg::LN2_SHIFT);
      end
   end

   assign out_valid = vr_ff;
   assign out_side = sr_ff;
   assign out_ln = ln_ff;

endmodule

// ===== sv/nhs_tk.sv =====
module nhs_tk (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  nhs_pkg::side_type               in_side,
   input  logic signed [nhs_pkg::LNW-1:0]  in_ln,
   input  logic [nhs_pkg::MODW-1:0]        bulk,
   input  logic [nhs_pkg::MODW-1:0]        shear,
   output logic                            out_valid,
   output nhs_pkg::side_type               out_side,
   output nhs_pkg::num_type                out_num [4]
);

   logic [4:0]               v_ff;
   nhs_pkg::side_type        s_ff [5];

   logic signed [nhs_pkg::MODW:0] lam;
   logic signed [nhs_pkg::BW-1:0] bm [3];
   logic signed [61:0]       pl_lo_in, pl_hi_in, pl_lo_ff, pl_hi_ff;
   logic signed [61:0]       pg_lo_in [3];
   logic signed [61:0]       pg_hi_in [3];
   logic signed [61:0]       pg_lo_ff [3];
   logic signed [61:0]       pg_hi_ff [3];

   logic signed [87:0]       full_lam;
   logic signed [83:0]       full_g [3];
   logic signed [63:0]       diag_ff;
   logic signed [63:0]       gt_ff [3];

   logic signed [63:0]       tk_in [4];
   logic signed [63:0]       tk_ff [4];
   logic signed [nhs_pkg::CW-1:0] c_in [4];
   logic signed [nhs_pkg::CW-1:0] c_ff [4];

   logic signed [65:0]       pp_lo_in [4][2];
   logic signed [65:0]       pp_hi_in [4][2];
   logic signed [65:0]       pp_lo_ff [4][2];
   logic signed [65:0]       pp_hi_ff [4][2];
   nhs_pkg::num_type         num_in [4];
   nhs_pkg::num_type         num_ff [4];

   // Partial products of lambda*ln J and G*Bm, cut at bit 20
   always_comb begin
      lam = signed'({1'b0, bulk}) - signed'({1'b0, shear});
      bm[0] = in_side.bm00;
      bm[1] = in_side.bm01;
      bm[2] = in_side.bm11;
      pl_lo_in = lam * signed'({1'b0, in_ln[19:0]});
      pl_hi_in = lam * signed'(in_ln[nhs_pkg::LNW-1:20]);
      for (int b = 0; b < 3; b++) begin
         pg_lo_in[b] = signed'({1'b0, shear[19:0]}) * bm[b];
         pg_hi_in[b] = signed'({1'b0, shear[nhs_pkg::MODW-1:20]}) * bm[b];
      end
   end

   // Recombine and take the scaled bits
   always_comb begin
      full_lam = (88'(pl_hi_ff) <<< 20) + 88'(pl_lo_ff);
      for (int b = 0; b < 3; b++) begin
         full_g[b] = (84'(pg_hi_ff[b]) <<< 20) + 84'(pg_lo_ff[b]);
      end
   end

   // Kirchhoff stress and cofactor matrix
   always_comb begin
      tk_in[0] = gt_ff[0] + diag_ff;
      tk_in[1] = gt_ff[1];
      tk_in[2] = gt_ff[1];
      tk_in[3] = gt_ff[2] + diag_ff;
      c_in[0] = nhs_pkg::CW'(s_ff[1].h11) + nhs_pkg::CW'(nhs_pkg::ONE);
      c_in[1] = -nhs_pkg::CW'(s_ff[1].h10);
      c_in[2] = -nhs_pkg::CW'(s_ff[1].h01);
      c_in[3] = nhs_pkg::CW'(s_ff[1].h00) + nhs_pkg::CW'(nhs_pkg::ONE);
   end

   // TK * C in halves of TK: lane n = i*2+j, term k
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 2; k++) begin
               pp_lo_in[i*2+j][k] = signed'({1'b0, tk_ff[i*2+k][31:0]}) * c_ff[k*2+j];
               pp_hi_in[i*2+j][k] = signed'(tk_ff[i*2+k][63:32]) * c_ff[k*2+j];
            end
         end
      end
   end

   // Sum the partials into the numerator
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         num_in[n] = (nhs_pkg::NW'(pp_hi_ff[n][0]) <<< 32) + nhs_pkg::NW'(pp_lo_ff[n][0])
                   + (nhs_pkg::NW'(pp_hi_ff[n][1]) <<< 32) + nhs_pkg::NW'(pp_lo_ff[n][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0] <= in_side;
         for (int s = 1; s < 5; s++) begin
            s_ff[s] <= s_ff[s-1];
         end
         pl_lo_ff <= pl_lo_in;
         pl_hi_ff <= pl_hi_in;
         pg_lo_ff <= pg_lo_in;
         pg_hi_ff <= pg_hi_in;
         diag_ff <= full_lam[87:24];
         for (int b = 0; b < 3; b++) begin
            gt_ff[b] <= full_g[b][83:20];
         end
         tk_ff <= tk_in;
         c_ff <= c_in;
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         num_ff <= num_in;
      end
   end

   assign out_valid = v_ff[4];
   assign out_side = s_ff[4];
   assign out_num = num_ff;

endmodule

// ===== sv/nhs_div.sv =====
module nhs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  nhs_pkg::side_type     in_side,
   input  nhs_pkg::num_type      in_num [4],
   output logic                  out_valid,
   output logic                  out_inv,
   output nhs_pkg::stress_type   out_stress [4]
);

   localparam int STEPS = nhs_pkg::NW;

   logic                         v_ff [0:STEPS];
   logic                         inv_ff [0:STEPS];
   logic [nhs_pkg::DW-1:0]       d_ff [0:STEPS];
   logic                         neg_ff [0:STEPS][4];
   logic [nhs_pkg::DW-1:0]       r_ff [0:STEPS][4];
   logic [nhs_pkg::NW-1:0]       q_ff [0:STEPS][4];

   logic [nhs_pkg::NW-1:0]       mag_in [4];
   logic [nhs_pkg::DW:0]         r2 [0:STEPS-1][4];
   logic                         ge [0:STEPS-1][4];
   logic [nhs_pkg::DW-1:0]       r_in [1:STEPS][4];
   logic [nhs_pkg::NW-1:0]       q_in [1:STEPS][4];

   nhs_pkg::stress_type          st_in [4];
   nhs_pkg::stress_type          st_ff [4];
   logic                         ov_ff;
   logic                         oinv_ff;
   logic [nhs_pkg::NW-1:0]       q_last;

   // Sign and magnitude of each numerator
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         mag_in[n] = in_num[n][nhs_pkg::NW-1] ? nhs_pkg::NW'(-in_num[n])
                                              : nhs_pkg::NW'(in_num[n]);
      end
   end

   // One restoring quotient bit per stage and lane
   always_comb begin
      for (int s = 0; s < STEPS; s++) begin
         for (int n = 0; n < 4; n++) begin
            r2[s][n] = {r_ff[s][n], q_ff[s][n][nhs_pkg::NW-1]};
            ge[s][n] = r2[s][n] >= {1'b0, d_ff[s]};
            r_in[s+1][n] = ge[s][n] ? nhs_pkg::DW'(r2[s][n] - {1'b0, d_ff[s]})
                                    : nhs_pkg::DW'(r2[s][n]);
            q_in[s+1][n] = {q_ff[s][n][nhs_pkg::NW-2:0], ge[s][n]};
         end
      end
   end

   // Apply sign, saturate, zero an inverted element
   always_comb begin
      q_last = '0;
      for (int n = 0; n < 4; n++) begin
         q_last = q_ff[STEPS][n];
         if (inv_ff[STEPS]) begin
            st_in[n] = '0;
         end else if (neg_ff[STEPS][n]) begin
            st_in[n] = (q_last > nhs_pkg::SAT_LIMIT) ? nhs_pkg::STRESS_MIN
                                                      : -signed'(q_last[nhs_pkg::SW-1:0]);
         end else begin
            st_in[n] = (q_last >= nhs_pkg::SAT_LIMIT) ? nhs_pkg::STRESS_MAX
                                                       : signed'(q_last[nhs_pkg::SW-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) begin
            v_ff[s] <= 1'b0;
         end
         ov_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s <= STEPS; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
         ov_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff[0] <= in_side.inv;
         d_ff[0] <= in_side.jac[nhs_pkg::DW-1:0];
         for (int n = 0; n < 4; n++) begin
            neg_ff[0][n] <= in_num[n][nhs_pkg::NW-1];
            r_ff[0][n] <= '0;
            q_ff[0][n] <= mag_in[n];
         end
         for (int s = 1; s <= STEPS; s++) begin
            inv_ff[s] <= inv_ff[s-1];
            d_ff[s] <= d_ff[s-1];
            for (int n = 0; n < 4; n++) begin
               neg_ff[s][n] <= neg_ff[s-1][n];
               r_ff[s][n] <= r_in[s][n];
               q_ff[s][n] <= q_in[s][n];
            end
         end
         st_ff <= st_in;
         oinv_ff <= inv_ff[STEPS];
      end
   end

   assign out_valid = ov_ff;
   assign out_inv = oinv_ff;
   assign out_stress = st_ff;

endmodule

// ===== sv/neo_hookean_stress_2d_top.sv =====
// Compressible neo-Hookean first Piola stress for one 2x2 displacement gradient
// per transfer. The block is a single pipeline that takes a new gradient every
// cycle while req_stall is low. Its sections in order form J and the Bm terms,
// take ln J (leading-one search, normalise, one squaring multiply per log2
// fraction bit over 32 stages, scale by ln 2), form the Kirchhoff stress and
// its product with the cofactor of F, and divide by J one quotient bit per
// stage over the 98-bit numerator. While a result is held on the output the
// whole pipeline holds and req_stall is raised. An element with J <= 0 returns
// zero stresses with rsp_inverted_element set. Write the moduli only while no
// item is in flight.
module neo_hookean_stress_2d_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [nhs_pkg::GW-1:0]         req_grad_xx,
   input  logic signed [nhs_pkg::GW-1:0]         req_grad_xy,
   input  logic signed [nhs_pkg::GW-1:0]         req_grad_yx,
   input  logic signed [nhs_pkg::GW-1:0]         req_grad_yy,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [nhs_pkg::SW-1:0]         rsp_stress_xx,
   output logic signed [nhs_pkg::SW-1:0]         rsp_stress_xy,
   output logic signed [nhs_pkg::SW-1:0]         rsp_stress_yx,
   output logic signed [nhs_pkg::SW-1:0]         rsp_stress_yy,
   output logic                                  rsp_inverted_element,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [nhs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [nhs_pkg::MODW-1:0]              csr_wdata
);

   logic                        en;
   logic [nhs_pkg::MODW-1:0]    bulk_ff;
   logic [nhs_pkg::MODW-1:0]    shear_ff;

   logic                        f_valid;
   nhs_pkg::side_type           f_side;
   logic                        l_valid;
   nhs_pkg::side_type           l_side;
   logic signed [nhs_pkg::LNW-1:0] l_ln;
   logic                        t_valid;
   nhs_pkg::side_type           t_side;
   nhs_pkg::num_type            t_num [4];
   nhs_pkg::stress_type         stress [4];

   // Hold the whole pipeline while a result waits
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // Modulus registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bulk_ff <= nhs_pkg::BULK_RESET;
         shear_ff <= nhs_pkg::SHEAR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            nhs_pkg::CSR_BULK:  bulk_ff <= csr_wdata;
            nhs_pkg::CSR_SHEAR: shear_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   nhs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .grad_xx   (req_grad_xx),
      .grad_xy   (req_grad_xy),
      .grad_yx   (req_grad_yx),
      .grad_yy   (req_grad_yy),
      .out_valid (f_valid),
      .out_side  (f_side)
   );

   nhs_log u_log (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .out_valid (l_valid),
      .out_side  (l_side),
      .out_ln    (l_ln)
   );

   nhs_tk u_tk (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (l_valid),
      .in_side   (l_side),
      .in_ln     (l_ln),
      .bulk      (bulk_ff),
      .shear     (shear_ff),
      .out_valid (t_valid),
      .out_side  (t_side),
      .out_num   (t_num)
   );

   nhs_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (t_valid),
      .in_side    (t_side),
      .in_num     (t_num),
      .out_valid  (rsp_valid),
      .out_inv    (rsp_inverted_element),
      .out_stress (stress)
   );

   assign rsp_stress_xx = stress[0];
   assign rsp_stress_xy = stress[1];
   assign rsp_stress_yx = stress[2];
   assign rsp_stress_yy = stress[3];

   // An inverted element carries zero stresses
   a_inverted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inverted_element |->
         rsp_stress_xx == '0 && rsp_stress_xy == '0 &&
         rsp_stress_yx == '0 && rsp_stress_yy == '0)
      else $error("inverted element with non-zero stress");

   // No result straight out of reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A shear write lands in the register
   a_shear_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == nhs_pkg::CSR_SHEAR |=> shear_ff == $past(csr_wdata))
      else $error("shear modulus write lost");

endmodule

// ===== tb/neo_hookean_stress_2d_top_tb.sv =====
module neo_hookean_stress_2d_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [nhs_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 8'd5;
   localparam logic [nhs_pkg::MODW-1:0] MOD_MAX = {nhs_pkg::MODW{1'b1}};
   localparam int NUM_PHASES = 6;
   localparam int RAND_PER_PHASE = 190;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic signed [nhs_pkg::GW-1:0] xx, xy, yx, yy;
   } grad_type;

   typedef struct {
      logic signed [nhs_pkg::SW-1:0] s [4];
      logic                          inv;
   } piola_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [nhs_pkg::GW-1:0]  req_grad_xx = '0, req_grad_xy = '0;
   logic signed [nhs_pkg::GW-1:0]  req_grad_yx = '0, req_grad_yy = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [nhs_pkg::SW-1:0]  rsp_stress_xx, rsp_stress_xy;
   logic signed [nhs_pkg::SW-1:0]  rsp_stress_yx, rsp_stress_yy;
   logic                           rsp_inverted_element;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [nhs_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [nhs_pkg::MODW-1:0]       csr_wdata = '0;

   // material moduli as the block should currently hold them
   logic [nhs_pkg::MODW-1:0] bulk_mod = nhs_pkg::BULK_RESET;
   logic [nhs_pkg::MODW-1:0] shear_mod = nhs_pkg::SHEAR_RESET;

   grad_type  pending_grads[$];
   grad_type  in_flight;
   piola_type expected_stress[$];
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_ask = 0;
   int        hold_seen = 0;
   int        hold_left = 0;
   int        errors = 0;

   neo_hookean_stress_2d_top u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // first Piola stress of one gradient under the given moduli
   function automatic piola_type piola_stress(grad_type g, logic [nhs_pkg::MODW-1:0] kb,
                                              logic [nhs_pkg::MODW-1:0] gs);
      logic signed [127:0] h [2][2];
      logic signed [127:0] c [2][2];
      logic signed [127:0] bm [2][2];
      logic signed [127:0] det, jac, lnj, lam, wide, num, quo, lim_hi, lim_lo;
      logic signed [63:0]  tk [2][2];
      logic signed [63:0]  diag;
      logic [63:0]         x, m, sq;
      logic [31:0]         frac;
      int                  k, e;
      piola_type           r;
      h[0][0] = g.xx; h[0][1] = g.xy; h[1][0] = g.yx; h[1][1] = g.yy;
      r.inv = 1'b0;
      for (int i = 0; i < 4; i++) r.s[i] = '0;
      det = h[0][0] * h[1][1] - h[0][1] * h[1][0];
      jac = nhs_pkg::ONE + h[0][0] + h[1][1] + (det >>> nhs_pkg::GRAD_FRAC_BITS);
      if (jac <= 0) begin
         r.inv = 1'b1;
         return r;
      end
      // log2 by repeated squaring, then scale by ln 2
      x = jac[63:0];
      k = 63;
      while (k > 0 && !x[k]) k--;
      m = (k >= 31) ? (x >> (k - 31)) : (x << (31 - k));
      e = k - nhs_pkg::GRAD_FRAC_BITS;
      frac = '0;
      for (int i = 0; i < nhs_pkg::SQ_STEPS; i++) begin
         sq = m * m;
         frac = frac << 1;
         if (sq[63]) begin
            frac[0] = 1'b1;
            m = sq >> 32;
         end else begin
            m = sq >> 31;
         end
      end
      wide = e;
      wide = (wide <<< 32) + {96'b0, frac};
      lnj = (wide * nhs_pkg::LN2_Q24) >>> nhs_pkg::LN2_SHIFT;
      lam = kb;
      wide = gs;
      lam = lam - wide;
      wide = lam * lnj;
      diag = 64'(wide >>> nhs_pkg::LN2_SHIFT);
      // Kirchhoff stress
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            bm[i][j] = ((h[i][0] * h[j][0]) >>> nhs_pkg::GRAD_FRAC_BITS)
                     + ((h[i][1] * h[j][1]) >>> nhs_pkg::GRAD_FRAC_BITS)
                     + h[i][j] + h[j][i];
            wide = gs;
            wide = wide * bm[i][j];
            tk[i][j] = 64'(wide >>> (nhs_pkg::GRAD_FRAC_BITS - 8));
            if (i == j) tk[i][j] = tk[i][j] + diag;
         end
      c[0][0] = nhs_pkg::ONE + h[1][1]; c[0][1] = -h[1][0];
      c[1][0] = -h[0][1];               c[1][1] = nhs_pkg::ONE + h[0][0];
      lim_hi = nhs_pkg::STRESS_MAX;
      lim_lo = nhs_pkg::STRESS_MIN;
      // multiply by the cofactor, divide by J and saturate
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            wide = tk[i][0];
            num = wide * c[0][j];
            wide = tk[i][1];
            num = num + wide * c[1][j];
            quo = num / jac;
            if (quo > lim_hi) r.s[i*2+j] = nhs_pkg::STRESS_MAX;
            else if (quo < lim_lo) r.s[i*2+j] = nhs_pkg::STRESS_MIN;
            else r.s[i*2+j] = quo[63:0];
         end
      return r;
   endfunction

   function automatic grad_type mk_grad(int a, int b, int c, int d);
      grad_type g;
      g.xx = a; g.xy = b; g.yx = c; g.yy = d;
      return g;
   endfunction

   function automatic logic signed [nhs_pkg::GW-1:0] rand_entry();
      int sel;
      sel = $urandom_range(9);
      if (sel < 6) return int'($urandom_range(0, 'h7FF_FFFF)) - 'h400_0000;
      if (sel < 8) return $urandom;
      return int'($urandom_range(0, 'h3FFF_FFFF)) - 'h2000_0000;
   endfunction

   // driver: offer queued gradients, predict each one as it transfers
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_stress.push_back(piola_stress(in_flight, bulk_mod, shear_mod));
         if (pending_grads.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            in_flight = pending_grads.pop_front();
            req_valid <= 1'b1;
            req_grad_xx <= in_flight.xx;
            req_grad_xy <= in_flight.xy;
            req_grad_yx <= in_flight.yx;
            req_grad_yy <= in_flight.yy;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random, or a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      piola_type exp_r;
      logic signed [nhs_pkg::SW-1:0] got [4];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_stress_xx, rsp_stress_xy, rsp_stress_yx, rsp_stress_yy};
         if (expected_stress.size() == 0) begin
            $display("%0t: unexpected result transfer xx=%0d", $time, rsp_stress_xx);
            errors++;
         end else begin
            exp_r = expected_stress.pop_front();
            for (int i = 0; i < 4; i++)
               if (got[i] !== exp_r.s[i]) begin
                  $display("%0t: stress[%0d] expected %0d actual %0d", $time, i,
                           exp_r.s[i], got[i]);
                  errors++;
               end
            if (rsp_inverted_element !== exp_r.inv) begin
               $display("%0t: inverted_element expected %0b actual %0b", $time,
                        exp_r.inv, rsp_inverted_element);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(logic [nhs_pkg::CSR_IDX_W-1:0] idx,
                            logic [nhs_pkg::MODW-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == nhs_pkg::CSR_BULK) bulk_mod = val;
      else if (idx == nhs_pkg::CSR_SHEAR) shear_mod = val;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_grads.size() > 0 || req_valid || expected_stress.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [nhs_pkg::MODW-1:0] kb [NUM_PHASES];
      logic [nhs_pkg::MODW-1:0] gs [NUM_PHASES];
      kb = '{nhs_pkg::BULK_RESET, '0, MOD_MAX, MOD_MAX, '0, '0};
      gs = '{nhs_pkg::SHEAR_RESET, '0, MOD_MAX, '0, MOD_MAX, '0};
      kb[5] = {8'($urandom_range(0, 255)), 32'($urandom)};
      gs[5] = {8'($urandom_range(0, 255)), 32'($urandom)};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         repeat (DRAIN_CYCLES) @(posedge clock);
         csr_write(nhs_pkg::CSR_BULK, kb[p]);
         csr_write(nhs_pkg::CSR_SHEAR, gs[p]);
         // index past the map must leave both moduli alone
         if (p == 0) csr_write(CSR_UNUSED, '1);
         send_idle_pct = (p < 2) ? 29 : (p < 4) ? 84 : 0;
         recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 29 : 0;
         if (p == 2) hold_ask <= hold_ask + 1;
         if (p == 0) begin
            pending_grads.push_back(mk_grad(0, 0, 0, 0));
            pending_grads.push_back(mk_grad('h7FFF_FFFF, 0, 0, 0));
            pending_grads.push_back(mk_grad(32'h8000_0000, 0, 0, 0));
            pending_grads.push_back(mk_grad(0, 'h7FFF_FFFF, 0, 0));
            pending_grads.push_back(mk_grad(0, 32'h8000_0000, 0, 0));
            pending_grads.push_back(mk_grad(0, 0, 'h7FFF_FFFF, 0));
            pending_grads.push_back(mk_grad(0, 0, 32'h8000_0000, 0));
            pending_grads.push_back(mk_grad(0, 0, 0, 'h7FFF_FFFF));
            pending_grads.push_back(mk_grad(0, 0, 0, 32'h8000_0000));
            pending_grads.push_back(mk_grad('h7FFF_FFFF, 'h7FFF_FFFF, 'h7FFF_FFFF,
                                            'h7FFF_FFFF));
            pending_grads.push_back(mk_grad(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                            32'h8000_0000));
            // J exactly zero, then just below and just above
            pending_grads.push_back(mk_grad(-nhs_pkg::ONE, 0, 0, 0));
            pending_grads.push_back(mk_grad(-nhs_pkg::ONE - 1, 0, 0, 0));
            pending_grads.push_back(mk_grad(-nhs_pkg::ONE + 1, 0, 0, 0));
            // nearly singular F: huge stress, saturates
            pending_grads.push_back(mk_grad(-nhs_pkg::ONE + 1, 'h7FFF_FFFF, 0,
                                            'h7FFF_FFFF));
            pending_grads.push_back(mk_grad('h100_0000, -'h80_0000, 'h40_0000, -'h20_0000));
            pending_grads.push_back(mk_grad(nhs_pkg::ONE, nhs_pkg::ONE, -nhs_pkg::ONE,
                                            nhs_pkg::ONE));
            pending_grads.push_back(mk_grad(1, -1, 1, -1));
         end
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            // sender pause until every result is in
            if (n == RAND_PER_PHASE / 2) wait_drained();
            pending_grads.push_back(mk_grad(rand_entry(), rand_entry(), rand_entry(),
                                            rand_entry()));
         end
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("neo_hookean_stress_2d_top_tb OK");
      end else begin
         $display("neo_hookean_stress_2d_top_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("neo_hookean_stress_2d_top_tb NOT OK");
      $finish;
   end

endmodule
